// ===== rtl/cmfrgb_pkg.sv =====
// Shared types and constants of the RGB cross median filter.
// Has no dependencies; used by cross_median_filter_rgb_unit.

package cmfrgb_pkg;

	// default line buffer depth in pixels
	localparam int DEF_MAX_WIDTH = 4096;

	// field and register widths
	localparam int CHAN_W       = 8;
	localparam int PIX_W        = 3 * CHAN_W;
	localparam int WIDTH_REG_W  = 13;
	localparam int HEIGHT_REG_W = 16;
	localparam int CFG_INDEX_W  = 1;
	localparam int CFG_DATA_W   = 16;

	// register reset values
	localparam int IMG_WIDTH_RST  = 2560;
	localparam int IMG_HEIGHT_RST = 1600;

	// smallest frame edge the filter works on
	localparam int MIN_EDGE = 3;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [PIX_W-1:0]  pixel_t;

	// four channel values left after the minimum is taken out
	typedef struct packed {
		chan_t b;
		chan_t c;
		chan_t d;
		chan_t e;
	} quad_t;

	// per-pixel position flags carried down the pipeline
	typedef struct packed {
		logic has_first; // row >= 1: pixel of the row above is emitted
		logic last_row;  // row H-1: a zero border pixel follows
		logic interior;  // emitted pixel gets the median
		logic last_col;  // column W-1
	} item_flags_t;

endpackage

// ===== rtl/cross_median_filter_rgb_unit.sv =====
// Five-point cross median filter for a raster RGB pixel stream, top level.
// Depends on cmfrgb_pkg (types, widths, register indexes).
//
// Usage:
//   Pixels enter in raster order on the in_* channel (valid/ready). Pixel (r,c)
//   releases output pixel (r-1,c): per channel the median of that pixel and its
//   four neighbors, or zero on the frame border. Row 0 releases nothing; each
//   pixel of the last row releases two transfers, pixel (H-2,c) and then the
//   zero border pixel (H-1,c) with run_last set. frame_end marks (H-1,W-1).
//   Two line buffers (MAX_WIDTH x 24 bits each, one read port apiece) hold the
//   two rows above; a prefetch of the next column of the upper buffer supplies
//   the center pixel, so each buffer is read once per pixel.
//   Pipeline: memory read at the transfer edge, then first half of the compare
//   network, then second half into the output register. Throughput: one pixel
//   per cycle while the receiver does not stall, set by the single read port per
//   buffer; on the last row each pixel makes two output transfers, and the one
//   output port sets the pace.
//   Reset: counters go to row 0, column 0 and the registers take 2560 x 1600.
//   Line buffers are not cleared; no clearing pass. A register write restarts
//   the frame at row 0, column 0.
//   Receiver stall: the output register holds its pixel, the pipeline fills
//   and in_ready drops once all three stages are occupied.

module cross_median_filter_rgb_unit
	import cmfrgb_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// pixel input
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [CHAN_W-1:0]      in_red,
	input  logic [CHAN_W-1:0]      in_green,
	input  logic [CHAN_W-1:0]      in_blue,
	// pixel output
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [CHAN_W-1:0]      out_red,
	output logic [CHAN_W-1:0]      out_green,
	output logic [CHAN_W-1:0]      out_blue,
	output logic                   run_last,
	output logic                   frame_end
);

	localparam int COL_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int REQ_W    = 15;
	localparam int RST_W    = (IMG_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : IMG_WIDTH_RST;
	localparam logic [COL_W-1:0] WLAST_RST = COL_W'(RST_W - 1);
	localparam logic [HEIGHT_REG_W-1:0] HLAST_RST = HEIGHT_REG_W'(IMG_HEIGHT_RST - 1);

	// compare-exchange front half: take the minimum out of five values
	function automatic quad_t med_front(input chan_t a0, input chan_t b0, input chan_t c0,
			input chan_t d0, input chan_t e0);
		chan_t a, t;
		quad_t q;
		a = a0;
		q.b = b0;
		q.c = c0;
		q.d = d0;
		q.e = e0;
		if (a > q.b) begin t = a; a = q.b; q.b = t; end
		if (a > q.c) begin t = a; a = q.c; q.c = t; end
		if (a > q.d) begin t = a; a = q.d; q.d = t; end
		if (a > q.e) begin t = a; a = q.e; q.e = t; end
		return q;
	endfunction

	// back half: drop the next smallest, then the least of the rest is the median
	function automatic chan_t med_back(input quad_t q0);
		quad_t q;
		chan_t t;
		q = q0;
		if (q.b > q.c) begin t = q.b; q.b = q.c; q.c = t; end
		if (q.b > q.d) begin t = q.b; q.b = q.d; q.d = t; end
		if (q.b > q.e) begin t = q.b; q.b = q.e; q.e = t; end
		if (q.c > q.d) q.c = q.d;
		if (q.c > q.e) q.c = q.e;
		return q.c;
	endfunction

	// ---------------------------------------------------------------
	// configuration and counters
	logic [COL_W-1:0]        wlast_q;
	logic [HEIGHT_REG_W-1:0] hlast_q;
	logic [COL_W-1:0]        col_q;
	logic [HEIGHT_REG_W-1:0] row_q;

	logic [REQ_W-1:0]        w_req, w_sel;
	logic [HEIGHT_REG_W-1:0] h_req, h_sel;

	// clamp requested frame size to the supported range
	always_comb begin
		w_req = REQ_W'(cfg_data[WIDTH_REG_W-1:0]);
		h_req = cfg_data[HEIGHT_REG_W-1:0];
		if (w_req < REQ_W'(MIN_EDGE)) begin
			w_sel = REQ_W'(MIN_EDGE);
		end else if (w_req > REQ_W'(MAX_WIDTH)) begin
			w_sel = REQ_W'(MAX_WIDTH);
		end else begin
			w_sel = w_req;
		end
		h_sel = (h_req < HEIGHT_REG_W'(MIN_EDGE)) ? HEIGHT_REG_W'(MIN_EDGE) : h_req;
	end

	logic accept;
	logic col_wrap;
	logic [COL_W-1:0] col_next;

	assign accept   = in_valid & in_ready;
	assign col_wrap = (col_q == wlast_q);
	assign col_next = col_wrap ? '0 : col_q + 1'b1;

	// register decode; any write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= WLAST_RST;
			hlast_q <= HLAST_RST;
			col_q   <= '0;
			row_q   <= '0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_IMAGE_WIDTH:  wlast_q <= COL_W'(w_sel - REQ_W'(1));
				CFG_IMAGE_HEIGHT: hlast_q <= h_sel - HEIGHT_REG_W'(1);
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_next;
			if (col_wrap) begin
				row_q <= (row_q == hlast_q) ? '0 : row_q + 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// pipeline handshake
	logic valid_s1, valid_s2;
	logic o_first_q, o_second_q;
	logic out_done, load_o, move2, move1;

	assign out_valid = o_first_q | o_second_q;
	assign out_done  = out_ready & out_valid & ~(o_first_q & o_second_q);
	assign load_o    = valid_s2 & (~out_valid | out_done);
	assign move2     = ~valid_s2 | load_o;
	assign move1     = ~valid_s1 | move2;
	assign in_ready  = move1;

	// ---------------------------------------------------------------
	// stage 0: line buffer reads at transfer
	pixel_t line_prev  [MAX_WIDTH];
	pixel_t line_prev2 [MAX_WIDTH];
	pixel_t lp_rd_q, lp2_rd_q;

	logic        s1_leave;
	pixel_t      cur_s1;
	logic [COL_W-1:0] col_s1;
	item_flags_t flags_s1;
	item_flags_t flags_in;

	assign s1_leave = valid_s1 & move2;

	always_comb begin
		flags_in.has_first = (row_q != '0);
		flags_in.last_row  = (row_q == hlast_q);
		flags_in.interior  = (row_q[HEIGHT_REG_W-1:1] != '0) && (col_q != '0) && !col_wrap;
		flags_in.last_col  = col_wrap;
	end

	// upper buffer reads the next column ahead (column 0 at row end)
	always_ff @(posedge clk) begin
		if (accept) begin
			lp_rd_q  <= line_prev[col_next];
			lp2_rd_q <= line_prev2[col_q];
			cur_s1   <= {in_red, in_green, in_blue};
			col_s1   <= col_q;
			flags_s1 <= flags_in;
		end
	end

	// ---------------------------------------------------------------
	// stage 1: window assembly, write-back, front of compare network
	pixel_t mid_q, left_q;
	pixel_t right_s1, mid_s1;
	quad_t  q_r, q_g, q_b;
	quad_t  q_r_s2, q_g_s2, q_b_s2;
	item_flags_t flags_s2;

	// center comes from the previous pixel's prefetch; right is this read
	assign mid_s1   = mid_q;
	assign right_s1 = flags_s1.last_col ? '0 : lp_rd_q;

	always_comb begin
		q_r = med_front(lp2_rd_q[23:16], cur_s1[23:16], mid_s1[23:16],
				left_q[23:16], right_s1[23:16]);
		q_g = med_front(lp2_rd_q[15:8], cur_s1[15:8], mid_s1[15:8],
				left_q[15:8], right_s1[15:8]);
		q_b = med_front(lp2_rd_q[7:0], cur_s1[7:0], mid_s1[7:0],
				left_q[7:0], right_s1[7:0]);
	end

	// rows shift down one buffer as the pixel leaves stage 1
	always_ff @(posedge clk) begin
		if (s1_leave) begin
			line_prev[col_s1]  <= cur_s1;
			line_prev2[col_s1] <= mid_s1;
			mid_q    <= lp_rd_q;
			left_q   <= mid_s1;
			q_r_s2   <= q_r;
			q_g_s2   <= q_g;
			q_b_s2   <= q_b;
			flags_s2 <= flags_s1;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: back of compare network into the output register
	pixel_t o_px_q;
	logic   o_fend_q;

	always_ff @(posedge clk) begin
		if (load_o) begin
			o_px_q   <= flags_s2.interior ?
				{med_back(q_r_s2), med_back(q_g_s2), med_back(q_b_s2)} : '0;
			o_fend_q <= flags_s2.last_col;
		end
	end

	// stage valids and output result tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			o_first_q  <= 1'b0;
			o_second_q <= 1'b0;
		end else begin
			if (move1) begin
				valid_s1 <= accept;
			end
			if (move2) begin
				valid_s2 <= valid_s1;
			end
			if (load_o) begin
				o_first_q  <= flags_s2.has_first;
				o_second_q <= flags_s2.last_row;
			end else if (out_done) begin
				o_first_q  <= 1'b0;
				o_second_q <= 1'b0;
			end else if (out_valid && out_ready) begin
				// first of two transfers taken; border pixel next
				o_first_q <= 1'b0;
			end
		end
	end

	// output fields: the border pixel after the first result is zero
	assign out_red   = o_first_q ? o_px_q[23:16] : '0;
	assign out_green = o_first_q ? o_px_q[15:8] : '0;
	assign out_blue  = o_first_q ? o_px_q[7:0] : '0;
	assign run_last  = ~(o_first_q & o_second_q);
	assign frame_end = ~o_first_q & o_second_q & o_fend_q;

`ifndef SYNTHESIS
	// prefetch never reads the entry written back in the same cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_leave && accept) |-> (col_next != col_s1))
		else $error("line buffer read and write hit the same column");

	// column counter stays inside the frame
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= wlast_q)
		else $error("column counter beyond frame width");

	// last column wraps to column 0
	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg_write && col_wrap) |=> (col_q == '0))
		else $error("column counter did not wrap");

	// frame end only on the final transfer of a pixel
	a_fend_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> run_last)
		else $error("frame_end without run_last");
`endif

endmodule

// ===== tb/cross_median_filter_rgb_unit_test.sv =====
// Self-checking testbench for the RGB cross median filter: random and directed frames,
// a line-buffer predictor and an in-order result check. Depends on cmfrgb_pkg and
// cross_median_filter_rgb_unit.

module cross_median_filter_rgb_unit_test;
	import cmfrgb_pkg::*;

	localparam int MAX_W          = DEF_MAX_WIDTH;
	localparam int RANDOM_ITEMS   = 1550;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int MAX_REPORTS    = 60;

	// one output pixel as the block should present it
	typedef struct {
		chan_t red;
		chan_t green;
		chan_t blue;
		logic  last_of_run;
		logic  last_of_frame;
	} out_px_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	logic        in_valid = 1'b0;
	logic        in_ready;
	chan_t       in_red = '0;
	chan_t       in_green = '0;
	chan_t       in_blue = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	chan_t       out_red;
	chan_t       out_green;
	chan_t       out_blue;
	logic        run_last;
	logic        frame_end;

	// stimulus and expectation stores
	pixel_t  pixel_feed_q[$];
	out_px_t filtered_q[$];
	int unsigned errors = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned quiet_cycles = 0;

	// predictor state: the two rows above, counters and geometry
	bit [PIX_W-1:0]          row_above [MAX_W];
	bit [PIX_W-1:0]          row_above2 [MAX_W];
	bit [PIX_W-1:0]          mid_left = '0;
	int unsigned             pred_col = 0;
	int unsigned             pred_row = 0;
	logic [WIDTH_REG_W-1:0]  width_reg = WIDTH_REG_W'(IMG_WIDTH_RST);
	logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_REG_W'(IMG_HEIGHT_RST);

	// hand-picked 3x3 frames: rails and alternating bit patterns with ties
	pixel_t directed_px [18] = '{
		24'hFFFFFF, 24'h000000, 24'hFF00FF,
		24'h00FF00, 24'h80807F, 24'hFFFFFF,
		24'h010101, 24'h000000, 24'hFEFEFE,
		24'h555555, 24'hAAAAAA, 24'h555555,
		24'hAAAAAA, 24'h555555, 24'hAAAAAA,
		24'h555555, 24'hAAAAAA, 24'h555555
	};

	cross_median_filter_rgb_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.run_last  (run_last),
		.frame_end (frame_end)
	);

	always #1 clk = ~clk;

	function automatic int unsigned eff_width(logic [WIDTH_REG_W-1:0] w);
		if (w < MIN_EDGE)
			return MIN_EDGE;
		if (w > MAX_W)
			return MAX_W;
		return w;
	endfunction

	function automatic int unsigned eff_height(logic [HEIGHT_REG_W-1:0] h);
		return (h < MIN_EDGE) ? MIN_EDGE : h;
	endfunction

	// median of five by sorting a copy
	function automatic chan_t median_of_five(chan_t a, chan_t b, chan_t c, chan_t d, chan_t e);
		chan_t v [5];
		chan_t t;
		v = '{a, b, c, d, e};
		for (int i = 1; i < 5; i++)
			for (int j = i; j > 0 && v[j-1] > v[j]; j--) begin
				t = v[j];
				v[j] = v[j-1];
				v[j-1] = t;
			end
		return v[2];
	endfunction

	// advance the predictor by one accepted pixel and queue what it releases
	task automatic filter_pixel(pixel_t cur);
		int unsigned w, h, c, r;
		pixel_t mid, above, right, res;
		logic last_row;
		out_px_t px;
		w = eff_width(width_reg);
		h = eff_height(height_reg);
		c = pred_col;
		r = pred_row;
		if (c >= w)
			c = w - 1;
		mid = row_above[c];
		above = row_above2[c];
		right = (c + 1 < w) ? row_above[c+1] : '0;
		last_row = (r == h - 1);
		res = '0;
		if (r >= 1) begin
			// interior pixel of the row above gets the cross median per channel
			if (r - 1 >= 1 && r - 1 <= h - 2 && c >= 1 && c <= w - 2)
				for (int sh = 0; sh < PIX_W; sh += CHAN_W)
					res[sh +: CHAN_W] = median_of_five(above[sh +: CHAN_W], cur[sh +: CHAN_W],
						mid[sh +: CHAN_W], mid_left[sh +: CHAN_W], right[sh +: CHAN_W]);
			px.red = res[23:16];
			px.green = res[15:8];
			px.blue = res[7:0];
			px.last_of_run = !last_row;
			px.last_of_frame = 1'b0;
			filtered_q.push_back(px);
		end
		// last row: the zero border pixel of this row follows
		if (last_row) begin
			px.red = '0;
			px.green = '0;
			px.blue = '0;
			px.last_of_run = 1'b1;
			px.last_of_frame = (c == w - 1);
			filtered_q.push_back(px);
		end
		mid_left = mid;
		row_above2[c] = mid;
		row_above[c] = cur;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		pred_col = c;
		pred_row = r;
	endtask

	// pixel driver: holds valid and payload until the transfer
	always @(posedge clk) begin
		pixel_t nxt;
		if (arst_n) begin
			if (in_valid && in_ready)
				filter_pixel({in_red, in_green, in_blue});
			if (!in_valid || in_ready) begin
				if (pixel_feed_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pixel_feed_q.pop_front();
					in_valid <= 1'b1;
					in_red <= nxt[23:16];
					in_green <= nxt[15:8];
					in_blue <= nxt[7:0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(string tag, int unsigned want, int unsigned got);
		if (want != got) begin
			if (errors < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, tag, want, got);
			errors++;
		end
	endfunction

	// result monitor: compare each output transfer with the oldest expectation
	always @(posedge clk) begin
		out_px_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (filtered_q.size() == 0) begin
					if (errors < MAX_REPORTS)
						$display("%0t: unexpected result, expected none, actual %0h %0h %0h %b %b",
							$time, out_red, out_green, out_blue, run_last, frame_end);
					errors++;
				end else begin
					want = filtered_q.pop_front();
					check_field("out_red", want.red, out_red);
					check_field("out_green", want.green, out_green);
					check_field("out_blue", want.blue, out_blue);
					check_field("run_last", want.last_of_run, run_last);
					check_field("frame_end", want.last_of_frame, frame_end);
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("cross_median_filter_rgb_unit verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// wait until every pixel is sent and every result seen, then let the pipe settle
	task automatic wait_drained();
		while (pixel_feed_q.size() != 0 || in_valid || filtered_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == CFG_IMAGE_WIDTH)
			width_reg = data[WIDTH_REG_W-1:0];
		else
			height_reg = data[HEIGHT_REG_W-1:0];
		pred_col = 0;
		pred_row = 0;
	endtask

	// new geometry on an idle block; each write restarts the frame
	task automatic configure(logic [CFG_DATA_W-1:0] wdata, logic [CFG_DATA_W-1:0] hdata);
		wait_drained();
		write_reg(CFG_IMAGE_WIDTH, wdata);
		write_reg(CFG_IMAGE_HEIGHT, hdata);
		@(posedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	function automatic chan_t rand_chan(int unsigned mode);
		chan_t picks [6] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
		if (mode == 0)
			return chan_t'($urandom_range(255));
		return picks[$urandom_range(5)];
	endfunction

	task automatic feed_random(int unsigned n, int unsigned mode);
		for (int i = 0; i < n; i++)
			pixel_feed_q.push_back({rand_chan(mode), rand_chan(mode), rand_chan(mode)});
	endtask

	initial begin
		int unsigned sent, phase, n, frame;
		logic [CFG_DATA_W-1:0] wdata, hdata;
		sent = 0;
		phase = 0;
		send_idle_pct = 35;
		recv_idle_pct = 51;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset geometry: a few pixels of row 0 release nothing
		feed_random(4, 0);
		// width 0 and height 1 both act as 3; then two back-to-back 3x3 frames
		configure(16'hE000, 16'd1);
		foreach (directed_px[i])
			pixel_feed_q.push_back(directed_px[i]);

		while (sent < RANDOM_ITEMS) begin
			if (sent < RANDOM_ITEMS / 3) begin
				send_idle_pct = 35;
				recv_idle_pct = 51;
			end else if (sent < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 51;
				recv_idle_pct = 35;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			phase++;
			wdata = CFG_DATA_W'($urandom);
			hdata = '0;
			if (phase == 4) begin
				// tallest frame, cut off after a few rows
				wdata[WIDTH_REG_W-1:0] = WIDTH_REG_W'($urandom_range(3, 6));
				hdata = 16'hFFFF;
				n = eff_width(wdata[WIDTH_REG_W-1:0]) * 4 + $urandom_range(0, 2);
			end else if (phase == 9) begin
				// widest line, clamped from the register maximum; row 0 and part of row 1
				wdata[WIDTH_REG_W-1:0] = '1;
				hdata = 16'd3;
				n = MAX_W + 40;
			end else begin
				if ($urandom_range(9) == 0)
					wdata[WIDTH_REG_W-1:0] = WIDTH_REG_W'($urandom_range(0, 2));
				else
					wdata[WIDTH_REG_W-1:0] = WIDTH_REG_W'($urandom_range(3, 10));
				if ($urandom_range(9) == 0)
					hdata = CFG_DATA_W'($urandom_range(0, 2));
				else
					hdata = CFG_DATA_W'($urandom_range(3, 8));
				frame = eff_width(wdata[WIDTH_REG_W-1:0]) * eff_height(hdata);
				case ($urandom_range(2))
					0: n = frame * $urandom_range(1, 3);
					1: n = $urandom_range(1, frame - 1);
					default: n = frame * $urandom_range(1, 2) + $urandom_range(1, frame - 1);
				endcase
			end
			configure(wdata, hdata);
			feed_random(n, $urandom_range(1));
			if (phase != 9)
				sent += n;
		end

		wait_drained();
		repeat (12) @(negedge clk);
		if (errors == 0)
			$display("cross_median_filter_rgb_unit verification clean");
		else
			$display("cross_median_filter_rgb_unit verification failed");
		$finish;
	end

endmodule
